// ----- sv/pcsg_pkg.sv -----
// ----------------------------------------------------------------------------
// pcsg_pkg
// Shared constants, types and the per-channel shift arithmetic for the
// palette color shift and gamma block.
// ----------------------------------------------------------------------------
package pcsg_pkg;

  localparam int SHIFT_COUNT = 4;
  localparam int REG_COUNT   = 4;
  localparam int CHAN_W      = 8;
  localparam int GAMMA_DEPTH = 256;

  // register indexes on the configuration port
  localparam logic [1:0] REG_CONTENTS = 2'd0;
  localparam logic [1:0] REG_DAMAGE   = 2'd1;
  localparam logic [1:0] REG_BONUS    = 2'd2;
  localparam logic [1:0] REG_POWERUP  = 2'd3;

  // one byte per shift stage (percents or targets of one channel)
  typedef logic [SHIFT_COUNT-1:0][CHAN_W-1:0] pcsg_bytes_t;

  // stage load strobes from the shared control chain to each lane
  typedef struct packed {
    logic [SHIFT_COUNT-1:0] load;
  } pcsg_ctrl_t;

  // c + ((pct * (t - c)) >>> 8); stays in 0..255 since pct <= 255
  function automatic logic [CHAN_W-1:0] apply_shift(
    input logic [CHAN_W-1:0] c,
    input logic [CHAN_W-1:0] pct,
    input logic [CHAN_W-1:0] t
  );
    logic signed [CHAN_W:0]     diff;
    logic signed [2*CHAN_W+1:0] prod;
    logic signed [CHAN_W+1:0]   sum;
    diff = $signed({1'b0, t}) - $signed({1'b0, c});
    prod = $signed({1'b0, pct}) * diff;
    sum  = $signed({2'b00, c}) + $signed(prod[2*CHAN_W+1:CHAN_W]);
    return sum[CHAN_W-1:0];
  endfunction

endpackage

// ----- sv/pcsg_ram.sv -----
// ----------------------------------------------------------------------------
// pcsg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pcsg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/pcsg_lane.sv -----
// ----------------------------------------------------------------------------
// pcsg_lane
// One color channel: a chain of shift stages, one multiply per stage,
// each stage registered and loaded by the shared control chain.
// ----------------------------------------------------------------------------
module pcsg_lane (
  input  logic                      clk,
  input  pcsg_pkg::pcsg_ctrl_t      ctrl,
  input  logic [pcsg_pkg::CHAN_W-1:0] base,
  input  pcsg_pkg::pcsg_bytes_t     pct,
  input  pcsg_pkg::pcsg_bytes_t     target,
  output logic [pcsg_pkg::CHAN_W-1:0] chan
);

  logic [pcsg_pkg::CHAN_W-1:0] stage [pcsg_pkg::SHIFT_COUNT];

  always_ff @(posedge clk) begin
    for (int k = 0; k < pcsg_pkg::SHIFT_COUNT; k++) begin
      if (ctrl.load[k]) begin
        if (k == 0) begin
          stage[k] <= pcsg_pkg::apply_shift(base, pct[k], target[k]);
        end else begin
          stage[k] <= pcsg_pkg::apply_shift(stage[k-1], pct[k], target[k]);
        end
      end
    end
  end

  assign chan = stage[pcsg_pkg::SHIFT_COUNT-1];

endmodule

// ----- sv/palette_color_shift_gamma.sv -----
// ----------------------------------------------------------------------------
// palette_color_shift_gamma
// Palette entry color shift blend followed by a writable gamma table.
// ----------------------------------------------------------------------------
// Input words carry mode plus either a base entry (mode 0) or a gamma table
// write (mode 1); both use valid/ready. Output words carry the shifted and
// gamma-corrected entry, one per mode 0 word; mode 1 words give no output.
// Shift registers are written on cfg_write/cfg_index/cfg_data; the user must
// write them only while idle, as the block itself does not enforce it.
// Throughput: one word per cycle while the output is not stalled. A blend
// word passes one registered multiply stage per color shift in each of the
// three channel lanes, the first loaded at the accepting edge, then a registered gamma read.
// A gamma write lands in the table at the same point where blends read it,
// so word order is kept.
// Reset clears the shift registers and the pipeline valids; the gamma table
// reads as identity for every entry not yet written (per-entry valid flags).
// When out_ready is low the result holds; earlier stages keep filling any
// empty slots, and in_ready drops only once every stage is occupied.
// ----------------------------------------------------------------------------
module palette_color_shift_gamma (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [7:0]  base_red,
  input  logic [7:0]  base_green,
  input  logic [7:0]  base_blue,
  input  logic [7:0]  gamma_index,
  input  logic [7:0]  gamma_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue
);

  localparam int S = pcsg_pkg::SHIFT_COUNT;

  logic [31:0] shift_reg [pcsg_pkg::REG_COUNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < pcsg_pkg::REG_COUNT; i++) begin
        shift_reg[i] <= '0;
      end
    end else if (cfg_write) begin
      case (cfg_index)
        pcsg_pkg::REG_CONTENTS: shift_reg[0] <= cfg_data;
        pcsg_pkg::REG_DAMAGE:   shift_reg[1] <= cfg_data;
        pcsg_pkg::REG_BONUS:    shift_reg[2] <= cfg_data;
        pcsg_pkg::REG_POWERUP:  shift_reg[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  pcsg_pkg::pcsg_bytes_t pct, tgt_r, tgt_g, tgt_b;

  always_comb begin
    for (int k = 0; k < S; k++) begin
      pct[k]   = shift_reg[k][31:24];
      tgt_r[k] = shift_reg[k][23:16];
      tgt_g[k] = shift_reg[k][15:8];
      tgt_b[k] = shift_reg[k][7:0];
    end
  end

  // control chain: stage valid, mode and gamma write payload
  logic [S-1:0] sv;
  logic [S-1:0] smode;
  logic [7:0]   sidx [S];
  logic [7:0]   sval [S];
  logic [S:0]   go;
  logic         adv_out;
  pcsg_pkg::pcsg_ctrl_t ctrl;

  assign adv_out = !out_valid || out_ready;

  always_comb begin
    go[S] = adv_out;
    for (int k = S - 1; k >= 0; k--) begin
      go[k] = !sv[k] || go[k+1];
    end
    ctrl.load = go[S-1:0];
  end

  assign in_ready = go[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= '0;
    end else begin
      for (int k = 0; k < S; k++) begin
        if (go[k]) begin
          sv[k] <= (k == 0) ? in_valid : sv[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < S; k++) begin
      if (go[k]) begin
        if (k == 0) begin
          smode[k] <= mode;
          sidx[k]  <= gamma_index;
          sval[k]  <= gamma_value;
        end else begin
          smode[k] <= smode[k-1];
          sidx[k]  <= sidx[k-1];
          sval[k]  <= sval[k-1];
        end
      end
    end
  end

  logic [7:0] lane_r, lane_g, lane_b;

  pcsg_lane u_lane_r (
    .clk(clk), .ctrl(ctrl), .base(base_red), .pct(pct), .target(tgt_r), .chan(lane_r)
  );
  pcsg_lane u_lane_g (
    .clk(clk), .ctrl(ctrl), .base(base_green), .pct(pct), .target(tgt_g), .chan(lane_g)
  );
  pcsg_lane u_lane_b (
    .clk(clk), .ctrl(ctrl), .base(base_blue), .pct(pct), .target(tgt_b), .chan(lane_b)
  );

  // gamma stage: write or read at the tail of the chain
  logic gam_we, gam_re;
  logic [pcsg_pkg::GAMMA_DEPTH-1:0] gvalid;
  logic [7:0] rd_r, rd_g, rd_b;
  logic [7:0] idx_r, idx_g, idx_b;
  logic       hit_r, hit_g, hit_b;

  assign gam_we = adv_out && sv[S-1] && smode[S-1];
  assign gam_re = adv_out && sv[S-1] && !smode[S-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      gvalid    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (gam_we) begin
        gvalid[sidx[S-1]] <= 1'b1;
      end
      if (adv_out) begin
        out_valid <= sv[S-1] && !smode[S-1];
      end
    end
  end

  // hold the lookup index so an unwritten entry reads as identity
  always_ff @(posedge clk) begin
    if (gam_re) begin
      idx_r <= lane_r;
      idx_g <= lane_g;
      idx_b <= lane_b;
      hit_r <= gvalid[lane_r];
      hit_g <= gvalid[lane_g];
      hit_b <= gvalid[lane_b];
    end
  end

  pcsg_ram #(.WIDTH(8), .DEPTH(pcsg_pkg::GAMMA_DEPTH)) u_ram_r (
    .clk(clk), .we(gam_we), .waddr(sidx[S-1]), .wdata(sval[S-1]),
    .re(gam_re), .raddr(lane_r), .rdata(rd_r)
  );
  pcsg_ram #(.WIDTH(8), .DEPTH(pcsg_pkg::GAMMA_DEPTH)) u_ram_g (
    .clk(clk), .we(gam_we), .waddr(sidx[S-1]), .wdata(sval[S-1]),
    .re(gam_re), .raddr(lane_g), .rdata(rd_g)
  );
  pcsg_ram #(.WIDTH(8), .DEPTH(pcsg_pkg::GAMMA_DEPTH)) u_ram_b (
    .clk(clk), .we(gam_we), .waddr(sidx[S-1]), .wdata(sval[S-1]),
    .re(gam_re), .raddr(lane_b), .rdata(rd_b)
  );

  assign out_red   = hit_r ? rd_r : idx_r;
  assign out_green = hit_g ? rd_g : idx_g;
  assign out_blue  = hit_b ? rd_b : idx_b;

endmodule

// ----- sim/tb_palette_color_shift_gamma.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_palette_color_shift_gamma
// Self-checking bench for the palette color shift and gamma block: a clocked
// driver feeds blend and gamma-write words from a queue, a clocked monitor
// checks every output word against an in-bench predictor of the four shifts
// and the gamma table, with random idling on both sides and register phases.
// ----------------------------------------------------------------------------
module tb_palette_color_shift_gamma;

  localparam logic MODE_BLEND = 1'b0;
  localparam logic MODE_GAMMA = 1'b1;

  localparam int MAX_IDLE    = 17;
  localparam int DRAIN_QUIET = 12;
  localparam int HOLD_CYCLES = 200;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;
  localparam int PHASES      = 10;
  localparam int PHASE_WORDS = 110;

  localparam logic [1:0] REG_ORDER [4] = '{pcsg_pkg::REG_CONTENTS, pcsg_pkg::REG_DAMAGE,
                                           pcsg_pkg::REG_BONUS, pcsg_pkg::REG_POWERUP};

  typedef enum logic [1:0] {ENT_WORD, ENT_CFG, ENT_SQUEEZE, ENT_DRAIN} entry_kind_t;

  typedef struct {
    entry_kind_t kind;
    logic        mode;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  gidx;
    logic [7:0]  gval;
    logic [1:0]  reg_idx;
    logic [31:0] reg_val;
    int          gap;
  } stim_entry_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = pcsg_pkg::REG_CONTENTS;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        mode = MODE_BLEND;
  logic [7:0]  base_red = '0;
  logic [7:0]  base_green = '0;
  logic [7:0]  base_blue = '0;
  logic [7:0]  gamma_index = '0;
  logic [7:0]  gamma_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;

  palette_color_shift_gamma dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .base_red    (base_red),
    .base_green  (base_green),
    .base_blue   (base_blue),
    .gamma_index (gamma_index),
    .gamma_value (gamma_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [31:0] shift_cfg [pcsg_pkg::REG_COUNT];
  logic [7:0]  gamma_mirror [pcsg_pkg::GAMMA_DEPTH];

  stim_entry_t pending_entries [$];
  rgb_t        expected_rgb [$];

  int words_total    = 0;
  int words_accepted = 0;
  int results_seen   = 0;
  int mismatches     = 0;
  int squeeze_count  = 0;
  int squeeze_seen   = 0;
  int head_wait      = 0;
  int quiet_cycles   = 0;
  int rx_wait        = 0;
  int rx_hold        = 0;
  int stall_cycles   = 0;
  bit rx_calm        = 1'b0;
  stim_entry_t held_entry;

  // c + floor(pct * (t - c) / 256)
  function automatic logic [7:0] shift_toward(logic [7:0] c, logic [7:0] pct, logic [7:0] t);
    int delta;
    delta = (int'(pct) * (int'(t) - int'(c))) >>> 8;
    return 8'(int'(c) + delta);
  endfunction

  function automatic rgb_t blend_entry(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    rgb_t        px;
    logic [31:0] w;
    for (int k = 0; k < pcsg_pkg::SHIFT_COUNT; k++) begin
      w = shift_cfg[k];
      r = shift_toward(r, w[31:24], w[23:16]);
      g = shift_toward(g, w[31:24], w[15:8]);
      b = shift_toward(b, w[31:24], w[7:0]);
    end
    px.r = gamma_mirror[r];
    px.g = gamma_mirror[g];
    px.b = gamma_mirror[b];
    return px;
  endfunction

  task automatic predict_word(stim_entry_t e);
    if (e.mode == MODE_GAMMA) begin
      gamma_mirror[e.gidx] = e.gval;
    end else begin
      expected_rgb.push_back(blend_entry(e.red, e.green, e.blue));
    end
  endtask

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  // bias toward the channel extremes now and then
  function automatic logic [7:0] pick_byte();
    int sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return 8'h00;
    if (sel == 1) return 8'hff;
    return 8'($urandom());
  endfunction

  task automatic add_word(logic m, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                          logic [7:0] gi, logic [7:0] gv, int gap);
    stim_entry_t e;
    e = '{kind: ENT_WORD, default: '0};
    e.mode  = m;
    e.red   = r;
    e.green = g;
    e.blue  = b;
    e.gidx  = gi;
    e.gval  = gv;
    e.gap   = gap;
    pending_entries.push_back(e);
    words_total++;
  endtask

  task automatic add_marker(entry_kind_t k, logic [1:0] idx, logic [31:0] val);
    stim_entry_t e;
    e = '{kind: k, default: '0};
    e.reg_idx = idx;
    e.reg_val = val;
    pending_entries.push_back(e);
  endtask

  function automatic logic [31:0] pick_shift_word(int style);
    logic [31:0] w;
    w = $urandom();
    case (style)
      1: w[31:24] = 8'h00;
      2: w[31:24] = 8'hff;
      3: begin
        w[23:16] = w[2] ? 8'hff : 8'h00;
        w[15:8]  = w[3] ? 8'hff : 8'h00;
        w[7:0]   = w[4] ? 8'hff : 8'h00;
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic fill_stimulus();
    int gap_max;
    int style;
    // reset settings: no shift, identity table
    add_word(MODE_BLEND, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 0);
    add_word(MODE_BLEND, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 0);
    add_word(MODE_BLEND, 8'h12, 8'hab, 8'h7f, 8'h5a, 8'ha5, 3);
    // gamma writes at both ends of the table, base fields ignored
    add_word(MODE_GAMMA, 8'hff, 8'hff, 8'hff, 8'h00, 8'hff, 0);
    add_word(MODE_GAMMA, 8'h00, 8'h00, 8'h00, 8'hff, 8'h00, 0);
    add_word(MODE_BLEND, 8'h00, 8'hff, 8'h80, 8'h33, 8'h44, 0);
    add_word(MODE_BLEND, 8'hff, 8'h00, 8'h01, 8'hff, 8'hff, 5);
    // full-strength and mixed shifts
    add_marker(ENT_CFG, pcsg_pkg::REG_CONTENTS, 32'hffff_ffff);
    add_marker(ENT_CFG, pcsg_pkg::REG_DAMAGE,   32'hff00_0000);
    add_marker(ENT_CFG, pcsg_pkg::REG_BONUS,    32'h80ff_0080);
    add_marker(ENT_CFG, pcsg_pkg::REG_POWERUP,  32'h0112_3456);
    add_word(MODE_BLEND, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0);
    add_word(MODE_BLEND, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 0);
    add_word(MODE_BLEND, 8'h80, 8'h7f, 8'h01, 8'h00, 8'h00, 2);
    add_marker(ENT_CFG, pcsg_pkg::REG_CONTENTS, 32'hffff_ffff);
    add_marker(ENT_CFG, pcsg_pkg::REG_DAMAGE,   32'hffff_ffff);
    add_marker(ENT_CFG, pcsg_pkg::REG_BONUS,    32'hffff_ffff);
    add_marker(ENT_CFG, pcsg_pkg::REG_POWERUP,  32'hffff_ffff);
    add_word(MODE_BLEND, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0);
    add_word(MODE_BLEND, 8'hff, 8'h00, 8'hff, 8'h00, 8'h00, 0);
    // restore table ends, then blend through the full-strength shifts
    add_word(MODE_GAMMA, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0);
    add_word(MODE_GAMMA, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 0);
    add_word(MODE_BLEND, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0);
    add_word(MODE_BLEND, 8'h00, 8'h7f, 8'hff, 8'h00, 8'h00, 0);

    for (int p = 0; p < PHASES; p++) begin
      style = (p == 1) ? 1 : (p == 2) ? 2 : int'($urandom_range(0, 3));
      for (int k = 0; k < pcsg_pkg::REG_COUNT; k++) begin
        add_marker(ENT_CFG, REG_ORDER[k], pick_shift_word(style));
      end
      // back-to-back words in some phases
      gap_max = (p % 3 == 1 || p == 4) ? 0 : MAX_IDLE;
      if (p == 4) add_marker(ENT_SQUEEZE, pcsg_pkg::REG_CONTENTS, '0);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (p == 6 && n == PHASE_WORDS / 2) add_marker(ENT_DRAIN, pcsg_pkg::REG_CONTENTS, '0);
        add_word(($urandom_range(0, 5) == 0) ? MODE_GAMMA : MODE_BLEND,
                 pick_byte(), pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                 $urandom_range(0, gap_max));
      end
    end
  endtask

  // driver
  always @(posedge clk) begin
    logic        nv;
    logic        wr;
    stim_entry_t e;
    nv = in_valid;
    wr = 1'b0;
    if (rst) begin
      in_valid  <= 1'b0;
      cfg_write <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_word(held_entry);
        words_accepted++;
        nv = 1'b0;
      end
      if (in_valid || expected_rgb.size() != 0) quiet_cycles = 0;
      else quiet_cycles++;
      if (!nv && pending_entries.size() != 0) begin
        e = pending_entries[0];
        case (e.kind)
          ENT_WORD: begin
            if (head_wait < e.gap) begin
              head_wait++;
            end else begin
              mode        <= e.mode;
              base_red    <= e.red;
              base_green  <= e.green;
              base_blue   <= e.blue;
              gamma_index <= e.gidx;
              gamma_value <= e.gval;
              held_entry = e;
              nv = 1'b1;
              head_wait = 0;
              void'(pending_entries.pop_front());
            end
          end
          ENT_CFG: begin
            // write only once the pipeline has fully drained
            if (quiet_cycles >= DRAIN_QUIET) begin
              cfg_index <= e.reg_idx;
              cfg_data  <= e.reg_val;
              wr = 1'b1;
              shift_cfg[e.reg_idx] = e.reg_val;
              void'(pending_entries.pop_front());
            end
          end
          ENT_DRAIN: begin
            if (quiet_cycles >= DRAIN_QUIET) void'(pending_entries.pop_front());
          end
          ENT_SQUEEZE: begin
            squeeze_count <= squeeze_count + 1;
            void'(pending_entries.pop_front());
          end
          default: ;
        endcase
      end
      in_valid  <= nv;
      cfg_write <= wr;
    end
  end

  // monitor
  always @(posedge clk) begin
    logic nr;
    rgb_t want;
    nr = out_ready;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_rgb.size() == 0) begin
          report_mismatch($sformatf("unexpected word %02h %02h %02h",
                                    out_red, out_green, out_blue));
        end else begin
          want = expected_rgb.pop_front();
          if (out_red !== want.r)
            report_mismatch($sformatf("out_red got %02h want %02h", out_red, want.r));
          if (out_green !== want.g)
            report_mismatch($sformatf("out_green got %02h want %02h", out_green, want.g));
          if (out_blue !== want.b)
            report_mismatch($sformatf("out_blue got %02h want %02h", out_blue, want.b));
        end
        results_seen++;
        if ($urandom_range(0, 39) == 0) rx_calm = ~rx_calm;
        rx_wait = rx_calm ? 0 : $urandom_range(0, MAX_IDLE);
        nr = 1'b0;
      end
      if (squeeze_count != squeeze_seen) begin
        squeeze_seen = squeeze_count;
        rx_hold = HOLD_CYCLES;
      end
      if (rx_hold != 0) begin
        rx_hold--;
        nr = 1'b0;
      end else if (!nr) begin
        if (rx_wait != 0) rx_wait--;
        else nr = 1'b1;
      end
      out_ready <= nr;
    end
  end

  // watchdog: nothing moving for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    for (int k = 0; k < pcsg_pkg::REG_COUNT; k++) shift_cfg[k] = '0;
    for (int i = 0; i < pcsg_pkg::GAMMA_DEPTH; i++) gamma_mirror[i] = 8'(i);
    fill_stimulus();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    while (words_accepted != words_total) @(posedge clk);
    while (expected_rgb.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/pcsg_pkg.sv
sv/pcsg_ram.sv
sv/pcsg_lane.sv
sv/palette_color_shift_gamma.sv
sim/tb_palette_color_shift_gamma.sv
